>>> rtl/lgps_pkg.sv
`default_nettype none
package lgps_pkg;
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_SEL,
        ST_PICK,
        ST_EMIT,
        ST_CLR
    } t_state;
endpackage
`default_nettype wire

>>> rtl/lgps_if.sv
`default_nettype none
interface lgps_sample_if;
    logic        valid;
    logic        ready;
    logic [4:0]  point_index;
    logic [2:0]  processor_id;
    logic [31:0] sample_time;
    logic        last_sample;
    modport source (output valid, point_index, processor_id, sample_time, last_sample,
                    input ready);
    modport sink (input valid, point_index, processor_id, sample_time, last_sample,
                  output ready);
endinterface

interface lgps_assign_if;
    logic       valid;
    logic       ready;
    logic [4:0] assigned_point;
    logic [2:0] assigned_processor;
    logic       last_assignment;
    modport source (output valid, assigned_point, assigned_processor, last_assignment,
                    input ready);
    modport sink (input valid, assigned_point, assigned_processor, last_assignment,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/lpt_greedy_point_scheduler.sv
`default_nettype none
// Channel    Dir  Payload
// i_sample   in   point_index, processor_id, sample_time, last_sample
// o_assign   out  assigned_point, assigned_processor, last_assignment
//
// A plain sample is accepted and the block is ready again at once.
// A last sample starts a run: the bit-serial divider works out AVG_W (SUM_W+FRAC_BITS)
// quotient bits for each seen point, skips each unseen point and then leaves.
// Each assignment then takes a point scan over MAX_POINTS entries, a processor scan
// over MAX_PROCS entries and an emit step. A clearing pass over all points
// ends the run; i_sample.ready stays low for the whole run.
// Reset is synchronous, active low; it clears the state, flags, sums, counts, loads and output valid.
// The block holds in the emit step while the result register waits on o_assign.ready.
module lpt_greedy_point_scheduler #(
    parameter int MAX_POINTS = 32,
    parameter int MAX_PROCS  = 8,
    parameter int TIME_BITS  = 32,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    lgps_sample_if.sink       i_sample,
    lgps_assign_if.source     o_assign
);
    localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int RW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int SUM_W = TIME_BITS + 8;
    localparam int AVG_W = SUM_W + FRAC_BITS;
    localparam int DIV_N = AVG_W;
    localparam int DCW   = $clog2(DIV_N + 1);
    localparam int TUSE  = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int LW    = 48;
    localparam logic [LW-1:0] LOAD_MAX = {LW{1'b1}};
    localparam logic [DCW-1:0] DTOP = DCW'(DIV_N - 1);

    lgps_pkg::t_state r_state, n_state;

    logic [SUM_W-1:0]      r_sum [MAX_POINTS];
    logic [7:0]            r_cnt [MAX_POINTS];
    logic [AVG_W-1:0]      r_avg [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_pseen, r_done;
    logic [MAX_PROCS-1:0]  r_rseen;
    logic [LW-1:0]         r_load [MAX_PROCS];

    // shared scan index and bit-serial divider
    logic [PW:0]        r_idx;
    logic [DCW-1:0]     r_dcnt;
    logic [AVG_W-1:0]   r_quo;
    logic [8:0]         r_rem;
    logic [PW-1:0]      r_best;
    logic               r_found;
    logic [RW:0]        r_pidx;
    logic [RW-1:0]      r_proc;
    logic               r_pfound;
    logic               r_ovalid;
    logic [4:0]         r_opt;
    logic [2:0]         r_opr;
    logic               r_olast;

    logic [PW-1:0] w_i;
    logic [RW-1:0] w_p;
    logic [AVG_W-1:0] w_dividend;
    logic [8:0] w_trial;
    logic       w_ge;
    logic [LW-1:0] w_sum_load, w_avg_ext;
    logic [LW:0] w_add;
    logic w_remaining;

    assign w_i = r_idx[PW-1:0];
    assign w_p = r_pidx[RW-1:0];
    assign w_dividend = AVG_W'(r_sum[w_i]) << FRAC_BITS;
    assign w_trial = {r_rem[7:0], w_dividend[DTOP - r_dcnt]};
    assign w_ge = w_trial >= {1'b0, r_cnt[w_i]};
    assign w_avg_ext = LW'(r_avg[r_best]);
    assign w_add = {1'b0, r_load[r_proc]} + {1'b0, w_avg_ext};
    assign w_sum_load = w_add[LW] ? LOAD_MAX : w_add[LW-1:0];
    assign w_remaining = |(r_pseen & ~r_done);

    assign i_sample.ready = (r_state == lgps_pkg::ST_LOAD);
    assign o_assign.valid = r_ovalid;
    assign o_assign.assigned_point = r_opt;
    assign o_assign.assigned_processor = r_opr;
    assign o_assign.last_assignment = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgps_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lgps_pkg::ST_LOAD: begin
                if (i_sample.valid && i_sample.last_sample) n_state = lgps_pkg::ST_DIV;
            end
            lgps_pkg::ST_DIV: begin
                // advance to selection once every seen point is averaged
                if (r_idx == (PW+1)'(MAX_POINTS)) n_state = lgps_pkg::ST_SEL;
            end
            lgps_pkg::ST_SEL: begin
                if (!w_remaining) n_state = lgps_pkg::ST_CLR;
                else if (r_idx == (PW+1)'(MAX_POINTS)) n_state = lgps_pkg::ST_PICK;
            end
            lgps_pkg::ST_PICK: begin
                if (r_pidx == (RW+1)'(MAX_PROCS)) n_state = lgps_pkg::ST_EMIT;
            end
            lgps_pkg::ST_EMIT: begin
                if (!r_ovalid || o_assign.ready) n_state = lgps_pkg::ST_SEL;
            end
            lgps_pkg::ST_CLR: begin
                if (r_idx == (PW+1)'(MAX_POINTS)) n_state = lgps_pkg::ST_LOAD;
            end
            default: n_state = lgps_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pseen  <= '0;
            r_rseen  <= '0;
            r_done   <= '0;
            r_idx    <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
            r_pfound <= 1'b0;
            r_pidx   <= '0;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end
            for (int k = 0; k < MAX_PROCS; k++) r_load[k] <= '0;
        end else begin
            // drop the result once taken, unless the emit step refills it
            if (r_ovalid && o_assign.ready && r_state != lgps_pkg::ST_EMIT)
                r_ovalid <= 1'b0;
            unique case (r_state)
                lgps_pkg::ST_LOAD: begin
                    if (i_sample.valid) begin
                        if (32'(i_sample.processor_id) < MAX_PROCS)
                            r_rseen[RW'(i_sample.processor_id)] <= 1'b1;
                        if (32'(i_sample.point_index) < MAX_POINTS &&
                            r_cnt[PW'(i_sample.point_index)] != 8'hFF) begin
                            r_sum[PW'(i_sample.point_index)] <=
                                r_sum[PW'(i_sample.point_index)] +
                                SUM_W'(i_sample.sample_time[TUSE-1:0]);
                            r_cnt[PW'(i_sample.point_index)] <=
                                r_cnt[PW'(i_sample.point_index)] + 8'd1;
                            r_pseen[PW'(i_sample.point_index)] <= 1'b1;
                        end
                        r_idx  <= '0;
                        r_dcnt <= '0;
                        r_rem  <= '0;
                    end
                end
                lgps_pkg::ST_DIV: begin
                    if (r_idx != (PW+1)'(MAX_POINTS)) begin
                        if (!r_pseen[w_i]) begin
                            r_idx <= r_idx + 1'b1;
                        end else begin
                            // restoring division, one quotient bit per cycle
                            r_rem <= w_ge ? (w_trial - {1'b0, r_cnt[w_i]}) : w_trial;
                            r_quo <= {r_quo[AVG_W-2:0], w_ge};
                            if (r_dcnt == DTOP) begin
                                r_avg[w_i] <= {r_quo[AVG_W-2:0], w_ge};
                                r_dcnt <= '0;
                                r_rem  <= '0;
                                r_idx  <= r_idx + 1'b1;
                            end else begin
                                r_dcnt <= r_dcnt + 1'b1;
                            end
                        end
                    end else begin
                        r_idx <= '0;
                        r_found <= 1'b0;
                    end
                end
                lgps_pkg::ST_SEL: begin
                    if (!w_remaining) begin
                        r_idx <= '0;
                    end else if (r_idx != (PW+1)'(MAX_POINTS)) begin
                        if (r_pseen[w_i] && !r_done[w_i] &&
                            (!r_found || r_avg[w_i] > r_avg[r_best])) begin
                            r_best  <= w_i;
                            r_found <= 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_pidx   <= '0;
                        r_pfound <= 1'b0;
                        r_proc   <= '0;
                    end
                end
                lgps_pkg::ST_PICK: begin
                    if (r_pidx != (RW+1)'(MAX_PROCS)) begin
                        if (r_rseen[w_p] && (!r_pfound || r_load[w_p] < r_load[r_proc])) begin
                            r_proc   <= w_p;
                            r_pfound <= 1'b1;
                        end
                        r_pidx <= r_pidx + 1'b1;
                    end
                end
                lgps_pkg::ST_EMIT: begin
                    if (!r_ovalid || o_assign.ready) begin
                        if (r_pfound) r_load[r_proc] <= w_sum_load;
                        r_done[r_best] <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_opt    <= 5'(r_best);
                        r_opr    <= 3'(r_proc);
                        r_olast  <= (r_pseen & ~r_done) == (MAX_POINTS'(1) << r_best);
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                    end
                end
                lgps_pkg::ST_CLR: begin
                    // drop one point's state per cycle
                    if (r_idx != (PW+1)'(MAX_POINTS)) begin
                        r_sum[w_i] <= '0;
                        r_cnt[w_i] <= '0;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_pseen <= '0;
                        r_rseen <= '0;
                        r_done  <= '0;
                        for (int k = 0; k < MAX_PROCS; k++) r_load[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.ready |-> r_state == lgps_pkg::ST_LOAD) else $error("ready out of load");
    a_done_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done & ~r_pseen) == '0) else $error("done point not seen");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_assign.ready |=> r_ovalid && $stable(r_opt))
        else $error("result dropped");
endmodule
`default_nettype wire
